// ----- hw/rtl/ppcmmu_pkg.sv -----
// Package for the address translator: command and result codes, payload structs,
// controller states and the control and status structs between controller and datapath.
// It has no dependencies.
package ppcmmu_pkg;

    typedef enum logic [1:0] {
        CMD_TRANSLATE = 2'd0,
        CMD_REPLY     = 2'd1,
        CMD_BLOCK_WR  = 2'd2,
        CMD_SEG_WR    = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_FAULT = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    localparam logic [1:0] ACC_FETCH = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd2;

    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_MASK  = 2'd1;
    localparam logic [1:0] CFG_FETCH = 2'd2;
    localparam logic [1:0] CFG_DATA  = 2'd3;

    localparam logic [31:0] REMAP_LIMIT = 32'hFFE00000;
    localparam logic [31:0] REMAP_BASE  = 32'h08000000;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] effective_address;
        logic [1:0]  access_kind;
        logic        privileged;
        logic [31:0] entry_high_word;
        logic [31:0] entry_low_word;
        logic [4:0]  register_slot;
        logic [31:0] register_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] result_address;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctrl;

    typedef struct packed {
        logic has_result;
    } t_status;

    function automatic logic [31:0] remap(input logic [31:0] a);
        logic [31:0] r;
        r = a;
        if (a >= REMAP_LIMIT) begin
            r = a - REMAP_LIMIT + REMAP_BASE;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/powerpc_mmu_address_translator.sv -----
// Address translator, top level: an item is captured, then decided in the
// datapath, and its result, if any, waits in the output register until taken;
// no new item is accepted until then. Reset is synchronous and active low;
// it clears the configuration registers, the tables and the walk flags.
// Depends on ppcmmu_pkg, ppcmmu_ctrl and ppcmmu_dp.
module powerpc_mmu_address_translator #(
    parameter int BLOCK_ENTRIES = 8,
    parameter int GROUP_ENTRIES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  ppcmmu_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ppcmmu_pkg::t_out_item o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    ppcmmu_pkg::t_ctrl   ctrl;
    ppcmmu_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    ppcmmu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_status(status), .o_ctrl(ctrl)
    );

    ppcmmu_dp #(.BLOCK_ENTRIES(BLOCK_ENTRIES), .GROUP_ENTRIES(GROUP_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in_data),
        .i_cfg_we(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_ctrl(ctrl), .o_status(status), .o_item(o_out_data)
    );

endmodule

// ----- hw/rtl/ppcmmu_ctrl.sv -----
// Controller state machine of the address translator.
// Depends on ppcmmu_pkg.
module ppcmmu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  ppcmmu_pkg::t_status  i_status,
    output ppcmmu_pkg::t_ctrl    o_ctrl
);

    ppcmmu_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppcmmu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ppcmmu_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = ppcmmu_pkg::ST_EXEC;
            end
            ppcmmu_pkg::ST_EXEC: begin
                n_state = i_status.has_result ? ppcmmu_pkg::ST_OUT : ppcmmu_pkg::ST_IDLE;
            end
            ppcmmu_pkg::ST_OUT: begin
                if (i_out_ready) n_state = ppcmmu_pkg::ST_IDLE;
            end
            default: n_state = ppcmmu_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctrl      = '0;
        case (r_state)
            ppcmmu_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
            end
            ppcmmu_pkg::ST_EXEC: begin
                o_ctrl.exec = 1'b1;
            end
            ppcmmu_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ppcmmu_dp.sv -----
// Datapath of the address translator: registers, block and segment lookup,
// page table walk state and the result register. Depends on ppcmmu_pkg.
module ppcmmu_dp #(
    parameter int BLOCK_ENTRIES = 8,
    parameter int GROUP_ENTRIES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppcmmu_pkg::t_in_item  i_item,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  ppcmmu_pkg::t_ctrl     i_ctrl,
    output ppcmmu_pkg::t_status   o_status,
    output ppcmmu_pkg::t_out_item o_item
);

    logic [15:0] r_base;
    logic [8:0]  r_mask;
    logic        r_fetch_on, r_data_on;
    logic [31:0] r_bat [32];
    logic [31:0] r_seg [16];
    ppcmmu_pkg::t_in_item r_in;
    logic        r_walk_active, n_walk_active;
    logic [31:0] r_walk_addr, n_walk_addr;
    logic [23:0] r_vsid, n_vsid;
    logic [5:0]  r_api, n_api;
    logic        r_key, n_key;
    logic        r_wr, n_wr;
    logic [18:0] r_hash, n_hash;
    logic        r_sec, n_sec;
    logic [2:0]  r_idx, n_idx;
    ppcmmu_pkg::t_out_item r_out, n_out;
    logic        n_has;

    logic        fetch, write, trans_on, bat_hit;
    logic [31:0] bat_pa, seg, hi, lo;
    logic [10:0] page;
    logic        pte_hit;
    logic [1:0]  pp;

    function automatic logic [31:0] entry_addr(input logic [18:0] hash, input logic sec,
                                               input logic [2:0] idx, input logic [15:0] base,
                                               input logic [8:0] mask);
        logic [18:0] h;
        logic [31:0] a;
        h = (sec ? ~hash : hash) & {mask, 10'h3FF};
        a = {base, 16'h0} | {7'h0, h, 6'h0};
        return ppcmmu_pkg::remap(a) + {26'h0, idx, 3'h0};
    endfunction

    always_comb begin
        logic [31:0] up, low;
        logic [14:0] msk, blk;
        bat_hit = 1'b0;
        bat_pa  = '0;
        for (int i = BLOCK_ENTRIES - 1; i >= 0; i--) begin
            up  = r_bat[{fetch ? 1'b0 : 1'b1, i[2:0], 1'b0}];
            low = r_bat[{fetch ? 1'b0 : 1'b1, i[2:0], 1'b1}];
            msk = ~{4'h0, up[12:2]};
            blk = (r_in.effective_address[31:17] & ~msk) | (low[31:17] & msk);
            if (low[1:0] != 2'd0 && !(low[0] && write)
                    && (r_in.privileged ? up[1] : up[0])
                    && ((up[31:17] ^ r_in.effective_address[31:17]) & msk) == 15'h0) begin
                bat_hit = 1'b1;
                bat_pa  = {blk, r_in.effective_address[16:0]};
            end
        end
    end

    assign fetch    = r_in.access_kind == ppcmmu_pkg::ACC_FETCH;
    assign write    = r_in.access_kind == ppcmmu_pkg::ACC_WRITE;
    assign trans_on = fetch ? r_fetch_on : r_data_on;
    assign seg      = r_seg[r_in.effective_address[31:28]];
    assign page     = r_in.effective_address[27:17];
    assign hi       = r_in.entry_high_word;
    assign lo       = r_in.entry_low_word;
    assign pp       = lo[1:0];
    assign pte_hit  = hi[31] && hi[6] == r_sec && hi[30:7] == r_vsid && hi[5:0] == r_api
                      && !(r_key && pp == 2'd0)
                      && !(r_wr && (pp == 2'd3 || (r_key && pp == 2'd1)));

    always_comb begin
        n_walk_active = r_walk_active;
        n_walk_addr = r_walk_addr;
        n_vsid = r_vsid;
        n_api  = r_api;
        n_key  = r_key;
        n_wr   = r_wr;
        n_hash = r_hash;
        n_sec  = r_sec;
        n_idx  = r_idx;
        n_out  = r_out;
        n_has  = 1'b1;
        case (ppcmmu_pkg::t_cmd'(r_in.command))
            ppcmmu_pkg::CMD_TRANSLATE: begin
                n_walk_active = 1'b0;
                if (!trans_on) begin
                    n_out = '{ppcmmu_pkg::KIND_DONE, ppcmmu_pkg::remap(r_in.effective_address)};
                end else if (bat_hit) begin
                    n_out = '{ppcmmu_pkg::KIND_DONE, ppcmmu_pkg::remap(bat_pa)};
                end else if (seg[31] || (seg[28] && fetch)) begin
                    n_out = '{ppcmmu_pkg::KIND_FAULT, 32'h0};
                end else begin
                    n_walk_active = 1'b1;
                    n_walk_addr = r_in.effective_address;
                    n_vsid = seg[23:0];
                    n_api  = page[10:5];
                    n_key  = r_in.privileged ? seg[30] : seg[29];
                    n_wr   = write;
                    n_hash = seg[18:0] ^ {8'h0, page};
                    n_sec  = 1'b0;
                    n_idx  = 3'd0;
                    n_out  = '{ppcmmu_pkg::KIND_READ,
                               entry_addr(n_hash, 1'b0, 3'd0, r_base, r_mask)};
                end
            end
            ppcmmu_pkg::CMD_REPLY: begin
                if (!r_walk_active) begin
                    n_has = 1'b0;
                end else if (pte_hit) begin
                    n_walk_active = 1'b0;
                    n_out = '{ppcmmu_pkg::KIND_DONE, ppcmmu_pkg::remap(
                              {lo[31:12], 12'h0} | {15'h0, r_walk_addr[16:0]})};
                end else if ({1'b0, r_idx} + 4'd1 < 4'(GROUP_ENTRIES)) begin
                    n_idx = r_idx + 3'd1;
                    n_out = '{ppcmmu_pkg::KIND_READ,
                              entry_addr(r_hash, r_sec, n_idx, r_base, r_mask)};
                end else if (!r_sec) begin
                    n_sec = 1'b1;
                    n_idx = 3'd0;
                    n_out = '{ppcmmu_pkg::KIND_READ,
                              entry_addr(r_hash, 1'b1, 3'd0, r_base, r_mask)};
                end else begin
                    n_walk_active = 1'b0;
                    n_out = '{ppcmmu_pkg::KIND_FAULT, 32'h0};
                end
            end
            default: begin
                n_out = '{ppcmmu_pkg::KIND_ACK, 32'h0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_mask <= '0;
            r_fetch_on <= 1'b0;
            r_data_on <= 1'b0;
            r_walk_active <= 1'b0;
            r_sec <= 1'b0;
            r_idx <= '0;
            for (int i = 0; i < 32; i++) r_bat[i] <= '0;
            for (int i = 0; i < 16; i++) r_seg[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ppcmmu_pkg::CFG_BASE:  r_base <= i_cfg_data[15:0];
                    ppcmmu_pkg::CFG_MASK:  r_mask <= i_cfg_data[8:0];
                    ppcmmu_pkg::CFG_FETCH: r_fetch_on <= i_cfg_data[0];
                    ppcmmu_pkg::CFG_DATA:  r_data_on <= i_cfg_data[0];
                    default: r_base <= r_base;
                endcase
            end
            if (i_ctrl.exec) begin
                r_walk_active <= n_walk_active;
                r_sec <= n_sec;
                r_idx <= n_idx;
                if (r_in.command == ppcmmu_pkg::CMD_BLOCK_WR)
                    r_bat[r_in.register_slot] <= r_in.register_value;
                if (r_in.command == ppcmmu_pkg::CMD_SEG_WR)
                    r_seg[r_in.register_slot[3:0]] <= r_in.register_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) r_in <= i_item;
        if (i_ctrl.exec) begin
            r_walk_addr <= n_walk_addr;
            r_vsid <= n_vsid;
            r_api <= n_api;
            r_key <= n_key;
            r_wr <= n_wr;
            r_hash <= n_hash;
            r_out <= n_out;
        end
    end

    assign o_status.has_result = n_has;
    assign o_item = r_out;

endmodule

// ----- tb/sv/tb_powerpc_mmu_address_translator.sv -----
// Self-checking testbench for powerpc_mmu_address_translator: block translation,
// segment faults, hashed page table walks driven by reply transfers, and remapping.
// Depends on ppcmmu_pkg and the translator RTL.
module tb_powerpc_mmu_address_translator;
    import ppcmmu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    powerpc_mmu_address_translator u_top (.*);

    always #5 i_clk = ~i_clk;

    // Translator state as predicted.
    logic [15:0] base_high = '0;
    logic [8:0]  hash_mask = '0;
    logic        fetch_on = 1'b0;
    logic        data_on = 1'b0;
    logic [31:0] block_words [32];
    logic [31:0] segments [16];
    logic        walking = 1'b0;
    logic [31:0] walk_ea = '0;
    logic [23:0] walk_vsid = '0;
    logic [5:0]  walk_api = '0;
    logic        walk_key = 1'b0;
    logic        walk_write = 1'b0;
    logic [18:0] walk_hash = '0;
    logic        walk_sec = 1'b0;
    logic [2:0]  walk_idx = '0;

    // Segment values as written by the stimulus, used to build matching entries.
    logic [31:0] stim_segments [16];

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int unsigned items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    logic in_taken = 1'b0;

    initial begin
        for (int i = 0; i < 32; i++) block_words[i] = '0;
        for (int i = 0; i < 16; i++) begin
            segments[i] = '0;
            stim_segments[i] = '0;
        end
    end

    function automatic logic [31:0] relocate(input logic [31:0] a);
        return (a >= 32'hFFE00000) ? a - 32'hFFE00000 + 32'h08000000 : a;
    endfunction

    function automatic logic [31:0] group_entry_address();
        logic [18:0] h;
        logic [31:0] a;
        h = walk_sec ? ~walk_hash : walk_hash;
        h = h & {hash_mask, 10'h3FF};
        a = {base_high, 16'h0} | ({13'h0, h} << 6);
        return relocate(a) + {26'h0, walk_idx, 3'b000};
    endfunction

    function automatic logic block_hit(input logic [31:0] ea, input logic data_set,
                                       input logic wr, input logic sup,
                                       output logic [31:0] pa);
        logic [31:0] up;
        logic [31:0] lo;
        logic [14:0] mask;
        logic [14:0] ablk;
        logic [14:0] blk;
        for (int i = 0; i < 8; i++) begin
            up = block_words[{data_set, i[2:0], 1'b0}];
            lo = block_words[{data_set, i[2:0], 1'b1}];
            mask = ~up[12:2] & 15'h7FFF;
            mask[14:11] = 4'hF;
            mask[10:0] = ~up[12:2];
            ablk = ea[31:17];
            if (lo[1:0] == 2'd0 || (lo[0] && wr)) continue;
            if (sup ? !up[1] : !up[0]) continue;
            if (((up[31:17] ^ ablk) & mask) != 15'd0) continue;
            blk = (ablk & ~mask) | (lo[31:17] & mask);
            pa = {blk, ea[16:0]};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_translation(input t_in_item it);
        t_out_item r;
        logic fetch;
        logic wr;
        logic [31:0] pa;
        logic [31:0] seg;
        logic [10:0] page;
        logic hit;
        r = '0;
        case (it.command)
            CMD_TRANSLATE: begin
                fetch = it.access_kind == ACC_FETCH;
                wr = it.access_kind == ACC_WRITE;
                walking = 1'b0;
                seg = segments[it.effective_address[31:28]];
                if (fetch ? !fetch_on : !data_on) begin
                    r = '{KIND_DONE, relocate(it.effective_address)};
                end else if (block_hit(it.effective_address, !fetch, wr, it.privileged, pa)) begin
                    r = '{KIND_DONE, relocate(pa)};
                end else if (seg[31] || (seg[28] && fetch)) begin
                    r = '{KIND_FAULT, 32'h0};
                end else begin
                    page = it.effective_address[27:17];
                    walking = 1'b1;
                    walk_ea = it.effective_address;
                    walk_vsid = seg[23:0];
                    walk_api = page[10:5];
                    walk_key = it.privileged ? seg[30] : seg[29];
                    walk_write = wr;
                    walk_hash = seg[18:0] ^ {8'h0, page};
                    walk_sec = 1'b0;
                    walk_idx = '0;
                    r = '{KIND_READ, group_entry_address()};
                end
                expected_results.push_back(r);
            end
            CMD_REPLY: begin
                if (walking) begin
                    hit = it.entry_high_word[31]
                        && it.entry_high_word[6] == walk_sec
                        && it.entry_high_word[30:7] == walk_vsid
                        && it.entry_high_word[5:0] == walk_api
                        && !(walk_key && it.entry_low_word[1:0] == 2'd0)
                        && !(walk_write && (it.entry_low_word[1:0] == 2'd3
                             || (walk_key && it.entry_low_word[1:0] == 2'd1)));
                    if (hit) begin
                        walking = 1'b0;
                        r = '{KIND_DONE, relocate({it.entry_low_word[31:12], 12'h0}
                                                  | {15'h0, walk_ea[16:0]})};
                    end else if (walk_idx != 3'd7) begin
                        walk_idx = walk_idx + 3'd1;
                        r = '{KIND_READ, group_entry_address()};
                    end else if (!walk_sec) begin
                        walk_sec = 1'b1;
                        walk_idx = '0;
                        r = '{KIND_READ, group_entry_address()};
                    end else begin
                        walking = 1'b0;
                        r = '{KIND_FAULT, 32'h0};
                    end
                    expected_results.push_back(r);
                end
            end
            CMD_BLOCK_WR: begin
                block_words[it.register_slot] = it.register_value;
                expected_results.push_back('{KIND_ACK, 32'h0});
            end
            default: begin
                segments[it.register_slot[3:0]] = it.register_value;
                expected_results.push_back('{KIND_ACK, 32'h0});
            end
        endcase
    endtask

    function automatic t_in_item random_item();
        logic [191:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(t_in_item)-1:0];
    endfunction

    task automatic queue_item(input t_in_item it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_translate(input logic [31:0] ea, input logic [1:0] acc,
                                   input logic sup);
        t_in_item it;
        it = random_item();
        it.command = CMD_TRANSLATE;
        it.effective_address = ea;
        it.access_kind = acc;
        it.privileged = sup;
        queue_item(it);
    endtask

    task automatic queue_reply(input logic [31:0] hi, input logic [31:0] lo);
        t_in_item it;
        it = random_item();
        it.command = CMD_REPLY;
        it.entry_high_word = hi;
        it.entry_low_word = lo;
        queue_item(it);
    endtask

    task automatic queue_register(input t_cmd cmd, input logic [4:0] slot,
                                  input logic [31:0] value);
        t_in_item it;
        it = random_item();
        it.command = cmd;
        it.register_slot = slot;
        it.register_value = value;
        if (cmd == CMD_SEG_WR) stim_segments[slot[3:0]] = value;
        queue_item(it);
    endtask

    function automatic logic [31:0] matching_entry(input logic [31:0] ea, input logic sec);
        logic [31:0] seg;
        seg = stim_segments[ea[31:28]];
        return {1'b1, seg[23:0], sec, ea[27:22]};
    endfunction

    // A translate followed by misses and then a matching entry.
    task automatic queue_walk(input logic [31:0] ea, input logic [1:0] acc,
                              input logic sup, input int misses);
        logic [31:0] hi;
        queue_translate(ea, acc, sup);
        for (int i = 0; i < misses; i++) begin
            hi = matching_entry(ea, i >= 8);
            case ($urandom_range(0, 3))
                0: hi = $urandom;
                1: hi[31] = 1'b0;
                2: hi[6] = ~hi[6];
                default: hi[5:0] = hi[5:0] + 6'd1 + 6'($urandom_range(0, 62));
            endcase
            queue_reply(hi, $urandom);
        end
        queue_reply(matching_entry(ea, misses >= 8), $urandom);
    endtask

    task automatic write_config(input logic [1:0] index, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_BASE:  base_high = value[15:0];
            CFG_MASK:  hash_mask = value[8:0];
            CFG_FETCH: fetch_on = value[0];
            default:   data_on = value[0];
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic queue_random_phase(input int unsigned count);
        int unsigned goal;
        int unsigned pick;
        logic [31:0] value;
        goal = items_queued + count;
        while (items_queued < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                value = $urandom;
                if ($urandom_range(0, 3) != 0) value[31] = 1'b0;
                queue_register(CMD_SEG_WR, 5'($urandom), value);
            end else if (pick < 18) begin
                queue_register(CMD_BLOCK_WR, 5'($urandom), $urandom);
            end else if (pick < 23) begin
                queue_item(random_item());
            end else begin
                queue_walk($urandom, 2'($urandom_range(0, 3)), 1'($urandom),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(8, 17)
                                                       : $urandom_range(0, 7));
            end
        end
    endtask

    // Sender: bursts of transfers separated by random gaps.
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_data <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: changing stall modes, plus long holds on request.
    int unsigned hold_left = 0;
    int unsigned stall_mode = 0;
    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = 300;
        end
        if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom);
                default: i_out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result kind %0d address %h",
                           o_out_data.result_kind, o_out_data.result_address);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_data.result_kind != want.result_kind) begin
                        $error("result_kind expected %0d actual %0d",
                               want.result_kind, o_out_data.result_kind);
                        errors++;
                    end
                    if (o_out_data.result_address != want.result_address) begin
                        $error("result_address expected %h actual %h",
                               want.result_address, o_out_data.result_address);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                items_taken++;
                predict_translation(i_in_data);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_config(CFG_BASE, 32'h0000FFFF);
        write_config(CFG_MASK, 32'h000001FF);
        write_config(CFG_FETCH, 32'h1);
        write_config(CFG_DATA, 32'h1);

        queue_register(CMD_SEG_WR, 5'd0, 32'h0);
        queue_register(CMD_SEG_WR, 5'd31, 32'hFFFFFFFF);
        queue_register(CMD_SEG_WR, 5'd1, 32'h10ABCDEF);
        queue_register(CMD_BLOCK_WR, 5'd16, 32'h0001FFFF);
        queue_register(CMD_BLOCK_WR, 5'd17, 32'h80000002);
        queue_reply(32'hFFFFFFFF, 32'hFFFFFFFF);
        queue_translate(32'h01234567, 2'd1, 1'b1);
        queue_translate(32'h01234567, ACC_WRITE, 1'b0);
        queue_translate(32'hFFFFFFFF, 2'd1, 1'b0);
        queue_translate(32'h10000000, ACC_FETCH, 1'b1);
        queue_translate(32'h10000000, 2'd3, 1'b0);
        queue_reply(32'h0, 32'h0);
        queue_walk(32'h1FFFFFFF, ACC_WRITE, 1'b1, 0);
        queue_reply(32'h80000000, 32'hFFFFF001);
        queue_walk(32'h20000000, 2'd1, 1'b0, 17);
        wait_idle();

        hold_requests++;
        queue_random_phase(200);
        wait_idle();

        write_config(CFG_BASE, 32'h0);
        write_config(CFG_MASK, 32'h0);
        write_config(CFG_FETCH, 32'h1);
        write_config(CFG_DATA, 32'h0);
        queue_random_phase(200);
        wait_idle();

        write_config(CFG_BASE, $urandom);
        write_config(CFG_MASK, $urandom);
        write_config(CFG_FETCH, 32'h0);
        write_config(CFG_DATA, 32'h1);
        queue_random_phase(200);
        wait_idle();

        write_config(CFG_BASE, $urandom);
        write_config(CFG_MASK, $urandom);
        write_config(CFG_FETCH, 32'h1);
        write_config(CFG_DATA, 32'h1);
        hold_requests++;
        queue_random_phase(200);
        wait_idle();

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
